// File: hdl/uart_request_deframer_crc8_top_macros.svh
// Assertion helpers for the port checker.
`ifndef UART_REQUEST_DEFRAMER_CRC8_TOP_MACROS_SVH
`define UART_REQUEST_DEFRAMER_CRC8_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define URD_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("deframer check failed");

// Next-cycle implication.
`define URD_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("deframer check failed");

`endif

// File: hdl/urd_pkg.sv
`default_nettype none

package urd_pkg;

  localparam int unsigned MAX_FRAME = 64;
  localparam int unsigned FRAME_AW  = $clog2(MAX_FRAME);
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RSP_IDX_W = 3;

  localparam logic [7:0] HDR_REQ  = 8'hAA;
  localparam logic [7:0] HDR_RSP  = 8'h55;
  localparam logic [7:0] RSP_SIZE = 8'h06;
  localparam logic [7:0] RSP_FILL = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic [LEN_W-1:0]     MIN_FRAME    = LEN_W'(5);
  localparam logic [LEN_W-1:0]     LAST_PAY_OFS = LEN_W'(6);
  localparam logic [FRAME_AW-1:0]  PAY_BASE     = FRAME_AW'(4);
  localparam logic [LEN_W-1:0]     CMD_HI_POS   = LEN_W'(2);
  localparam logic [LEN_W-1:0]     CMD_LO_POS   = LEN_W'(3);
  localparam logic [RSP_IDX_W-1:0] RSP_LAST     = RSP_IDX_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_BAD_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BAD_CRC = CFG_IDX_W'(1);

  localparam logic [7:0] BAD_LEN_RST = 8'd1;
  localparam logic [7:0] BAD_CRC_RST = 8'd2;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } urd_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_RD,
    ST_PAY,
    ST_NULL
  } urd_state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } urd_in_t;

  typedef struct packed {
    logic       route;
    logic [7:0] command_high;
    logic [7:0] command_low;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
  } urd_out_t;

  typedef struct packed {
    logic                en;
    logic [FRAME_AW-1:0] addr;
    logic [7:0]          data;
  } urd_ram_wr_t;

  typedef struct packed {
    logic                en;
    logic [FRAME_AW-1:0] addr;
  } urd_ram_rd_t;

  // CRC-8, poly 0xD5, MSB first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  localparam logic [7:0] HDR_CRC = crc8_step(8'h00, HDR_REQ);
  // check over 55 06 FF FF, the fixed part of every response
  localparam logic [7:0] RSP_PRE_CRC =
    crc8_step(crc8_step(crc8_step(crc8_step(8'h00, HDR_RSP), RSP_SIZE), RSP_FILL), RSP_FILL);

endpackage

`default_nettype wire

// File: hdl/uart_request_deframer_crc8_top.sv
// Request deframer for a byte stream from a serial receiver.
// Input channel (in_valid_i/in_ready_o, in_i): one received byte (mode 0) or
// an idle timeout tick (mode 1) per request. Output channel (out_valid_o /
// out_ready_i, out_o): route 0 carries the items of a good request (both
// command bytes plus one payload byte each), route 1 the six bytes of an
// error response 55 06 FF FF code crc. Config channel (cfg_valid_i, always
// ready): index 0 bad-length/timeout code, index 1 bad-check code; other
// indexes are ignored.
// A byte that yields no results leaves the sequencer idle and ready, so bytes
// can arrive back to back. A completing byte, a bad length byte or a timeout
// during a frame hands over to the emitter and the input is held off until
// its last result sits in the output register: response bytes go out at one
// per cycle while the receiver takes them, payload items each need a frame
// store read, then a load. A result passes the state register, for a payload
// the frame store read, then the output register. A stalled receiver simply
// holds the output register and the emitter waits on it.
// Reset: hunting for a header, codes back to 1 and 2, output empty. The frame
// store has no reset; only bytes of the current frame are ever read back.
`default_nettype none

module uart_request_deframer_crc8_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  urd_pkg::urd_in_t                  in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output urd_pkg::urd_out_t                 out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [urd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);
  import urd_pkg::*;

  urd_state_e  state_q, state_d;
  urd_phase_e  phase_q, phase_d;
  logic [LEN_W-1:0]     exp_len_q, exp_len_d;
  logic [LEN_W-1:0]     count_q, count_d;
  logic [7:0]           crc_q, crc_d;
  logic [7:0]           bad_len_q, bad_len_d;
  logic [7:0]           bad_crc_q, bad_crc_d;
  logic [7:0]           err_code_q, err_code_d;
  logic [RSP_IDX_W-1:0] err_idx_q, err_idx_d;
  logic [FRAME_AW-1:0]  pay_idx_q, pay_idx_d;
  logic [FRAME_AW-1:0]  pay_last_q, pay_last_d;
  logic [7:0]           cmd_hi_q, cmd_hi_d;
  logic [7:0]           cmd_lo_q, cmd_lo_d;
  logic                 out_valid_q, out_valid_d;
  urd_out_t             out_q, out_d;

  urd_ram_wr_t ram_wr;
  urd_ram_rd_t ram_rd;
  logic [7:0]  ram_rdata;

  logic             in_acc;
  logic             slot_free;
  logic             out_load;
  urd_out_t         out_item;
  logic             err_start;
  logic             pay_start;
  logic             null_start;
  logic             len_ok;
  logic             body_done;
  logic [LEN_W-1:0] count_inc;
  logic [7:0]       rsp_byte;

  urd_frame_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_i      (ram_rd),
    .rd_data_o (ram_rdata)
  );

  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign count_inc = count_q + LEN_W'(1);
  assign len_ok    = (in_i.rx_byte >= 8'(MIN_FRAME)) && (in_i.rx_byte <= 8'(MAX_FRAME));
  assign body_done = (count_inc == exp_len_q);

  always_comb begin
    case (err_idx_q)
      RSP_IDX_W'(0): rsp_byte = HDR_RSP;
      RSP_IDX_W'(1): rsp_byte = RSP_SIZE;
      RSP_IDX_W'(2): rsp_byte = RSP_FILL;
      RSP_IDX_W'(3): rsp_byte = RSP_FILL;
      RSP_IDX_W'(4): rsp_byte = err_code_q;
      default:       rsp_byte = crc8_step(RSP_PRE_CRC, err_code_q);
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (err_start) begin
          state_d = ST_ERR;
        end else if (pay_start) begin
          state_d = ST_RD;
        end else if (null_start) begin
          state_d = ST_NULL;
        end
      end
      ST_ERR: begin
        if (slot_free && (err_idx_q == RSP_LAST)) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: state_d = ST_PAY;
      ST_PAY: begin
        if (slot_free) begin
          state_d = (pay_idx_q == pay_last_q) ? ST_IDLE : ST_RD;
        end
      end
      ST_NULL: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    ram_rd      = '0;
    out_load    = 1'b0;
    out_item    = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_ERR: begin
        out_load = slot_free;
        out_item = '{route: 1'b1, command_high: 8'h00, command_low: 8'h00,
                     data_byte: rsp_byte, data_valid: 1'b1,
                     last: (err_idx_q == RSP_LAST)};
      end
      ST_RD: begin
        ram_rd.en   = 1'b1;
        ram_rd.addr = PAY_BASE + pay_idx_q;
      end
      ST_PAY: begin
        out_load = slot_free;
        out_item = '{route: 1'b0, command_high: cmd_hi_q, command_low: cmd_lo_q,
                     data_byte: ram_rdata, data_valid: 1'b1,
                     last: (pay_idx_q == pay_last_q)};
      end
      ST_NULL: begin
        out_load = slot_free;
        out_item = '{route: 1'b0, command_high: cmd_hi_q, command_low: cmd_lo_q,
                     data_byte: 8'h00, data_valid: 1'b0, last: 1'b1};
      end
      default: ;
    endcase
  end

  // frame parser and counters
  always_comb begin
    phase_d    = phase_q;
    exp_len_d  = exp_len_q;
    count_d    = count_q;
    crc_d      = crc_q;
    bad_len_d  = bad_len_q;
    bad_crc_d  = bad_crc_q;
    err_code_d = err_code_q;
    err_idx_d  = err_idx_q;
    pay_idx_d  = pay_idx_q;
    pay_last_d = pay_last_q;
    cmd_hi_d   = cmd_hi_q;
    cmd_lo_d   = cmd_lo_q;
    err_start  = 1'b0;
    pay_start  = 1'b0;
    null_start = 1'b0;
    ram_wr     = '{en: 1'b0, addr: count_q[FRAME_AW-1:0], data: in_i.rx_byte};

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BAD_LEN: bad_len_d = cfg_data_i;
        REG_BAD_CRC: bad_crc_d = cfg_data_i;
        default: ;
      endcase
    end

    if (in_acc) begin
      if (in_i.mode) begin
        // timeout drops a held header or partial frame
        if ((phase_q == PH_LEN) || (phase_q == PH_BODY)) begin
          phase_d    = PH_HUNT;
          count_d    = '0;
          exp_len_d  = '0;
          crc_d      = 8'h00;
          err_start  = 1'b1;
          err_code_d = bad_len_q;
        end
      end else begin
        case (phase_q)
          PH_LEN: begin
            if (!len_ok) begin
              err_start  = 1'b1;
              err_code_d = bad_len_q;
              if (in_i.rx_byte == HDR_REQ) begin
                phase_d   = PH_LEN;
                crc_d     = HDR_CRC;
                count_d   = LEN_W'(1);
                exp_len_d = '0;
              end else begin
                phase_d   = PH_HUNT;
                crc_d     = 8'h00;
                count_d   = '0;
                exp_len_d = '0;
              end
            end else begin
              phase_d   = PH_BODY;
              crc_d     = crc8_step(crc_q, in_i.rx_byte);
              exp_len_d = in_i.rx_byte[LEN_W-1:0];
              count_d   = LEN_W'(2);
            end
          end
          PH_BODY: begin
            ram_wr.en = 1'b1;
            if (count_q == CMD_HI_POS) begin
              cmd_hi_d = in_i.rx_byte;
            end
            if (count_q == CMD_LO_POS) begin
              cmd_lo_d = in_i.rx_byte;
            end
            if (!body_done) begin
              crc_d   = crc8_step(crc_q, in_i.rx_byte);
              count_d = count_inc;
            end else begin
              phase_d   = PH_HUNT;
              crc_d     = 8'h00;
              count_d   = '0;
              exp_len_d = '0;
              if (crc_q != in_i.rx_byte) begin
                err_start  = 1'b1;
                err_code_d = bad_crc_q;
              end else if (exp_len_q == MIN_FRAME) begin
                null_start = 1'b1;
              end else begin
                pay_start  = 1'b1;
                pay_idx_d  = '0;
                pay_last_d = FRAME_AW'(exp_len_q - LAST_PAY_OFS);
              end
            end
          end
          default: begin
            // hunting; the unused phase code behaves the same
            if (in_i.rx_byte == HDR_REQ) begin
              phase_d   = PH_LEN;
              crc_d     = HDR_CRC;
              count_d   = LEN_W'(1);
              exp_len_d = '0;
            end
          end
        endcase
      end
    end

    if (err_start) begin
      err_idx_d = '0;
    end else if ((state_q == ST_ERR) && slot_free) begin
      err_idx_d = err_idx_q + RSP_IDX_W'(1);
    end

    if ((state_q == ST_PAY) && slot_free) begin
      pay_idx_d = pay_idx_q + FRAME_AW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = out_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HUNT;
      exp_len_q   <= '0;
      count_q     <= '0;
      crc_q       <= 8'h00;
      bad_len_q   <= BAD_LEN_RST;
      bad_crc_q   <= BAD_CRC_RST;
      err_idx_q   <= '0;
      pay_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      exp_len_q   <= exp_len_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
      bad_len_q   <= bad_len_d;
      bad_crc_q   <= bad_crc_d;
      err_idx_q   <= err_idx_d;
      pay_idx_q   <= pay_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_code_q <= err_code_d;
    pay_last_q <= pay_last_d;
    cmd_hi_q   <= cmd_hi_d;
    cmd_lo_q   <= cmd_lo_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire

// File: hdl/urd_frame_ram.sv
`default_nettype none

module urd_frame_ram (
  input  logic                 clk_i,
  input  urd_pkg::urd_ram_wr_t wr_i,
  input  urd_pkg::urd_ram_rd_t rd_i,
  output logic [7:0]           rd_data_o
);
  import urd_pkg::*;

  logic [7:0] mem [MAX_FRAME];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: hdl/urd_port_chk.sv
`default_nettype none
`include "uart_request_deframer_crc8_top_macros.svh"

module urd_port_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input urd_pkg::urd_out_t out_o
);
  import urd_pkg::*;

  // a stalled result stays offered
  `URD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // no new request is taken while a run is still going out
  `URD_ASSERT_NOW(a_run_blocks_in, clk_i, rst_ni, out_valid_o && !out_o.last, !in_ready_o)

  // a response run is never interleaved with handler items
  `URD_ASSERT_NEXT(a_rsp_run, clk_i, rst_ni,
                   out_valid_o && out_ready_i && out_o.route && !out_o.last,
                   !out_valid_o || out_o.route)

  // response bytes carry no command and are always real
  `URD_ASSERT_NOW(a_rsp_shape, clk_i, rst_ni, out_valid_o && out_o.route,
                  out_o.data_valid && (out_o.command_high == 8'h00) &&
                  (out_o.command_low == 8'h00))

endmodule

bind uart_request_deframer_crc8_top urd_port_chk u_port_chk (.*);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import urd_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  // indexes that map to no register; writes there must leave both codes alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  urd_in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  urd_out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  uart_request_deframer_crc8_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  urd_in_t  rx_q[$];        // line bytes and ticks still to send
  urd_out_t outbound_q[$];  // handler items and response bytes still due

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_cnt = 0;
  int n_bytes = 0;
  int n_ticks = 0;
  int n_requests = 0;
  int n_responses = 0;
  int n_checked = 0;

  // shadow of the deframer
  urd_phase_e rx_phase = PH_HUNT;
  int         rx_len = 0;
  int         rx_cnt = 0;
  logic [7:0] rx_crc = 8'h00;
  logic [7:0] frame_buf [MAX_FRAME];
  logic [7:0] len_code = BAD_LEN_RST;
  logic [7:0] crc_code = BAD_CRC_RST;

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function automatic urd_out_t make_item(input logic route, input logic [7:0] ch,
                                         input logic [7:0] cl, input logic [7:0] d,
                                         input logic dv, input logic lst);
    urd_out_t it;
    it.route = route;
    it.command_high = ch;
    it.command_low = cl;
    it.data_byte = d;
    it.data_valid = dv;
    it.last = lst;
    return it;
  endfunction

  function automatic void expect_item(input urd_out_t it);
    outbound_q = {outbound_q, it};
  endfunction

  function automatic void hunt_reset();
    rx_phase = PH_HUNT;
    rx_len = 0;
    rx_cnt = 0;
    rx_crc = 8'h00;
  endfunction

  function automatic void take_header();
    frame_buf[0] = HDR_REQ;
    rx_crc = crc8_next(8'h00, HDR_REQ);
    rx_cnt = 1;
    rx_len = 0;
    rx_phase = PH_LEN;
  endfunction

  function automatic void queue_error_response(input logic [7:0] code);
    logic [7:0] rsp [6];
    logic [7:0] acc;
    rsp[0] = HDR_RSP;
    rsp[1] = RSP_SIZE;
    rsp[2] = RSP_FILL;
    rsp[3] = RSP_FILL;
    rsp[4] = code;
    acc = 8'h00;
    for (int i = 0; i < 5; i++) acc = crc8_next(acc, rsp[i]);
    rsp[5] = acc;
    for (int i = 0; i < 6; i++) expect_item(make_item(1'b1, 8'h00, 8'h00, rsp[i], 1'b1, i == 5));
    n_responses++;
  endfunction

  // Works out what one accepted request produces.
  function automatic void deframe_item(input urd_in_t it);
    logic [7:0] b;
    logic [7:0] chk;
    int len;
    int n;
    b = it.rx_byte;
    if (it.mode) begin
      n_ticks++;
      if (rx_phase == PH_LEN || rx_phase == PH_BODY) begin
        hunt_reset();
        queue_error_response(len_code);
      end
    end else begin
      n_bytes++;
      case (rx_phase)
        PH_LEN: begin
          if (b < MIN_FRAME || b > MAX_FRAME) begin
            // a length byte of 0xAA doubles as the next header
            if (b == HDR_REQ) take_header();
            else hunt_reset();
            queue_error_response(len_code);
          end else begin
            frame_buf[1] = b;
            rx_crc = crc8_next(rx_crc, b);
            rx_len = int'(b);
            rx_cnt = 2;
            rx_phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (rx_cnt < MAX_FRAME) frame_buf[rx_cnt] = b;
          if (rx_cnt + 1 < rx_len) rx_crc = crc8_next(rx_crc, b);
          rx_cnt++;
          if (rx_cnt >= rx_len) begin
            len = rx_len;
            chk = rx_crc;
            hunt_reset();
            if (chk != b) begin
              queue_error_response(crc_code);
            end else begin
              n_requests++;
              n = len - int'(MIN_FRAME);
              if (n == 0) begin
                expect_item(make_item(1'b0, frame_buf[2], frame_buf[3], 8'h00, 1'b0, 1'b1));
              end else begin
                for (int i = 0; i < n; i++)
                  expect_item(make_item(1'b0, frame_buf[2], frame_buf[3],
                                        frame_buf[4 + i], 1'b1, i == n - 1));
              end
            end
          end
        end
        default: begin
          if (b == HDR_REQ) take_header();
        end
      endcase
    end
  endfunction

  // Driver: one request per handshake, gaps at the sender's idle rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) deframe_item(in_i);
      if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_i <= rx_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  function automatic int field_err(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
    if (got === want) return 0;
    $error("%s: expected %h, got %h", name, want, got);
    return 1;
  endfunction

  // Monitor: compares every delivered item with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin : out_check
    urd_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outbound_q.size() == 0) begin
          $error("unexpected output item: route %0d data %h", out_o.route, out_o.data_byte);
          fail_cnt++;
        end else begin
          want = outbound_q.pop_front();
          n_checked++;
          fail_cnt += field_err("route", 8'(want.route), 8'(out_o.route))
                    + field_err("command_high", want.command_high, out_o.command_high)
                    + field_err("command_low", want.command_low, out_o.command_low)
                    + field_err("data_byte", want.data_byte, out_o.data_byte)
                    + field_err("data_valid", 8'(want.data_valid), 8'(out_o.data_valid))
                    + field_err("last", 8'(want.last), 8'(out_o.last));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void push_rx(input logic [7:0] b);
    urd_in_t t;
    t.mode = 1'b0;
    t.rx_byte = b;
    rx_q = {rx_q, t};
  endfunction

  function automatic void push_tick();
    urd_in_t t;
    t.mode = 1'b1;
    t.rx_byte = 8'($urandom_range(255));  // don't-care byte, toggled anyway
    rx_q = {rx_q, t};
  endfunction

  // Frame of total length len; cut != 0 replaces byte number cut by a tick,
  // spoil corrupts the check byte.
  function automatic void push_frame(input int len, input int cut, input bit spoil);
    logic [7:0] acc;
    logic [7:0] b;
    push_rx(HDR_REQ);
    if (cut == 1) begin
      push_tick();
      return;
    end
    acc = crc8_next(crc8_next(8'h00, HDR_REQ), 8'(len));
    push_rx(8'(len));
    for (int i = 2; i < len; i++) begin
      if (i == cut) begin
        push_tick();
        return;
      end
      if (i == len - 1) begin
        push_rx(spoil ? (acc ^ 8'($urandom_range(255, 1))) : acc);
      end else begin
        b = 8'($urandom_range(255));
        push_rx(b);
        acc = crc8_next(acc, b);
      end
    end
  endfunction

  task automatic random_traffic(input int n_live, input int s_pct, input int r_pct);
    int noise;
    int len;
    int r;
    logic [7:0] b;
    @(negedge clk_i);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    noise = 0;
    while (rx_q.size() - noise < n_live) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(MAX_FRAME, MIN_FRAME)
                                     : $urandom_range(12, MIN_FRAME);
      r = $urandom_range(99);
      if (r < 55) begin
        push_frame(len, 0, 1'b0);
      end else if (r < 67) begin
        push_frame(len, 0, 1'b1);
      end else if (r < 79) begin
        case ($urandom_range(2))
          0: b = 8'($urandom_range(MIN_FRAME - 1));
          1: b = 8'($urandom_range(255, MAX_FRAME + 1));
          default: b = HDR_REQ;
        endcase
        push_rx(HDR_REQ);
        push_rx(b);
      end else if (r < 89) begin
        push_frame(len, $urandom_range(len - 1, 1), 1'b0);
      end else begin
        if ($urandom_range(1)) begin
          push_tick();
        end else begin
          b = 8'($urandom_range(255));
          push_rx(b == HDR_REQ ? HDR_RSP : b);
        end
        noise++;
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_q.size() != 0 || in_valid_i || outbound_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BAD_LEN: len_code = val;
      REG_BAD_CRC: crc_code = val;
      default: ;
    endcase
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, with the codes still at their reset values
    @(negedge clk_i);
    send_idle_pct = 30;
    recv_idle_pct = 53;
    push_rx(8'h00);
    push_rx(8'hFF);
    push_tick();                 // tick while hunting: no response
    push_rx(HDR_REQ);
    push_rx(8'(MIN_FRAME - 1));  // length too short
    push_rx(HDR_REQ);
    push_rx(8'(MAX_FRAME + 1));  // length too long
    push_rx(HDR_REQ);            // next 0xAA is a bad length and a new header
    push_frame(MIN_FRAME, 0, 1'b0);
    push_frame(MIN_FRAME, 0, 1'b1);
    push_frame(MIN_FRAME, 1, 1'b0);  // timeout with only the header held
    push_frame(6, 3, 1'b0);          // timeout part way through the body
    wait_idle();

    write_reg(REG_BAD_LEN, 8'h00);
    write_reg(REG_BAD_CRC, 8'hFF);
    write_reg(REG_SPARE_2, 8'($urandom_range(255)));
    write_reg(REG_SPARE_3, 8'($urandom_range(255)));
    @(negedge clk_i);
    push_frame(MAX_FRAME, 0, 1'b0);
    random_traffic(80, 30, 53);
    wait_idle();

    write_reg(REG_BAD_LEN, 8'hFF);
    write_reg(REG_BAD_CRC, 8'h00);
    random_traffic(15, 53, 30);
    wait_idle();

    write_reg(REG_BAD_LEN, 8'($urandom_range(255)));
    write_reg(REG_BAD_CRC, 8'($urandom_range(255)));
    random_traffic(15, 0, 0);
    wait_idle();

    $display("Fed %0d line bytes and %0d idle ticks under three stall mixes and four code settings;",
             n_bytes, n_ticks);
    $display("checked %0d output items: %0d good requests, %0d error responses.",
             n_checked, n_requests, n_responses);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
